@@ design/llcp_pkg.sv @@
// Shared constants, widths and types for the line-line closest point block.
// Depends on nothing; every other file imports it.
`default_nettype none
package llcp_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // difference, product, dot, determinant and scaled numerator widths
   localparam int D_W  = COORD_WIDTH + 1;
   localparam int P_W  = 2 * D_W;
   localparam int E_W  = P_W + 2;
   localparam int Q_W  = 2 * E_W + 1;
   localparam int N_W  = Q_W + FRAC_BITS;
   localparam int T_W  = E_W + COORD_WIDTH + 1;
   localparam int NP_W = COORD_WIDTH + D_W;

   // split of a dot product into a signed upper half and an unsigned lower half
   localparam int L_W = E_W / 2;
   localparam int H_W = E_W - L_W;

   // divider: abs stage, init stage, one stage per quotient bit, output stage
   localparam int DIV_LAT = COORD_WIDTH + 3;

   localparam int LEPS_W     = 16;
   localparam int DEPS_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LEPS_W-1:0] LEPS_RESET = LEPS_W'(1);
   localparam logic [DEPS_W-1:0] DEPS_RESET = DEPS_W'(1);

   localparam logic [0:0] REG_LEPS = 1'b0;
   localparam logic [0:0] REG_DEPS = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [D_W-1:0]         diff_type;
   typedef logic signed [P_W-1:0]         prod_type;
   typedef logic signed [E_W-1:0]         dot_type;
   typedef logic signed [Q_W-1:0]         quad_type;
   typedef logic signed [N_W-1:0]         num_type;
   typedef logic signed [NP_W-1:0]        nprod_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam nprod_type FRAC_MASK = NP_W'((64'd1 << FRAC_BITS) - 64'd1);

   // side data that rides along the first division
   typedef struct {
      logic      bad;
      dot_type   e1343;
      dot_type   e4321;
      dot_type   e4343;
      coord_type p1 [3];
      coord_type p3 [3];
      diff_type  d21 [3];
      diff_type  d43 [3];
   } side_a_type;

   // side data that rides along the second division
   typedef struct {
      logic      bad;
      coord_type mua;
      coord_type p1 [3];
      coord_type p3 [3];
      diff_type  d21 [3];
      diff_type  d43 [3];
   } side_b_type;

endpackage
`default_nettype wire

@@ design/llcp_div.sv @@
// Pipelined signed divider, one quotient bit per stage, truncating and
// saturating to the coordinate range. Depends on llcp_pkg.
`default_nettype none
module llcp_div import llcp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  num_type   num,
   input  quad_type  den,
   output logic      out_valid,
   output coord_type quot
);

   logic                   v0_ff;
   logic                   sign0_ff;
   logic [N_W-1:0]         an0_ff;
   logic [Q_W-1:0]         ad0_ff;

   logic                   vld_ff  [COORD_WIDTH+1];
   logic                   sign_ff [COORD_WIDTH+1];
   logic                   ovf_ff  [COORD_WIDTH+1];
   logic [Q_W:0]           rem_ff  [COORD_WIDTH+1];
   logic [Q_W-1:0]         den_ff  [COORD_WIDTH+1];
   logic [COORD_WIDTH-1:0] lo_ff   [COORD_WIDTH+1];
   logic [COORD_WIDTH-1:0] quo_ff  [COORD_WIDTH+1];

   logic [Q_W:0]           rem_in  [COORD_WIDTH];
   logic                   bit_in  [COORD_WIDTH];

   logic                   out_valid_ff;
   coord_type              quot_ff;

   logic [COORD_WIDTH-1:0] q_fin;
   coord_type              quot_in;

   // magnitudes and result sign
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      sign0_ff <= num[N_W-1] ^ den[Q_W-1];
      an0_ff   <= num[N_W-1] ? N_W'(-num) : N_W'(num);
      ad0_ff   <= den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
   end

   // one restoring step per quotient bit
   always_comb begin
      for (int k = 0; k < COORD_WIDTH; k++) begin
         logic [Q_W:0] shifted;
         shifted   = {rem_ff[k][Q_W-1:0], lo_ff[k][COORD_WIDTH-1]};
         bit_in[k] = shifted >= (Q_W+1)'(den_ff[k]);
         rem_in[k] = bit_in[k] ? shifted - (Q_W+1)'(den_ff[k]) : shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= COORD_WIDTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= v0_ff;
         for (int k = 0; k < COORD_WIDTH; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
      // quotient needs more than the kept bits: flag overflow
      ovf_ff[0]  <= (Q_W+1)'(an0_ff[N_W-1:COORD_WIDTH]) >= (Q_W+1)'(ad0_ff);
      rem_ff[0]  <= (Q_W+1)'(an0_ff[N_W-1:COORD_WIDTH]);
      lo_ff[0]   <= an0_ff[COORD_WIDTH-1:0];
      den_ff[0]  <= ad0_ff;
      sign_ff[0] <= sign0_ff;
      quo_ff[0]  <= '0;
      for (int k = 0; k < COORD_WIDTH; k++) begin
         ovf_ff[k+1]  <= ovf_ff[k];
         rem_ff[k+1]  <= rem_in[k];
         lo_ff[k+1]   <= {lo_ff[k][COORD_WIDTH-2:0], 1'b0};
         den_ff[k+1]  <= den_ff[k];
         sign_ff[k+1] <= sign_ff[k];
         quo_ff[k+1]  <= {quo_ff[k][COORD_WIDTH-2:0], bit_in[k]};
      end
   end

   // apply sign and clamp
   always_comb begin
      q_fin = quo_ff[COORD_WIDTH];
      if (!sign_ff[COORD_WIDTH]) begin
         quot_in = (ovf_ff[COORD_WIDTH] || q_fin[COORD_WIDTH-1]) ? COORD_MAX
                                                                : coord_type'(q_fin);
      end else begin
         quot_in = (ovf_ff[COORD_WIDTH] ||
                    (q_fin[COORD_WIDTH-1] && (|q_fin[COORD_WIDTH-2:0])))
                   ? COORD_MIN : coord_type'(-q_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[COORD_WIDTH];
      end
      quot_ff <= quot_in;
   end

   assign out_valid = out_valid_ff;
   assign quot      = quot_ff;

endmodule
`default_nettype wire

@@ design/llcp_front.sv @@
// Front pipeline: differences, degeneracy test, dot products, determinant
// and numerator. Depends on llcp_pkg.
`default_nettype none
module llcp_front import llcp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  coord_type         pa1 [3],
   input  coord_type         pa2 [3],
   input  coord_type         pb1 [3],
   input  coord_type         pb2 [3],
   input  logic [LEPS_W-1:0] leps,
   input  logic [DEPS_W-1:0] deps,
   output logic              out_valid,
   output quad_type          numer,
   output quad_type          denom,
   output side_a_type        side
);

   localparam int FRONT_LAT = 7;

   logic [FRONT_LAT-1:0] vld_ff;

   coord_type p1_s1_ff [3], p3_s1_ff [3];
   diff_type  d13_ff [3], d43_s1_ff [3], d21_s1_ff [3];

   coord_type p1_s2_ff [3], p3_s2_ff [3];
   diff_type  d43_s2_ff [3], d21_s2_ff [3];
   prod_type  pr1343_ff [3], pr4321_ff [3], pr1321_ff [3], pr4343_ff [3], pr2121_ff [3];
   logic      deg_s2_ff;
   logic      small43, small21;

   dot_type    e1321_ff, e2121_ff;
   side_a_type s3_ff;

   dot_type                 mul_x [4], mul_y [4];
   logic signed [2*H_W-1:0] pp_hh_ff [4];
   logic signed [H_W+L_W:0] pp_hl_ff [4], pp_lh_ff [4];
   logic [2*L_W-1:0]        pp_ll_ff [4];
   side_a_type              s4_ff;

   logic signed [2*E_W-1:0] ma_ff, mb_ff, mc_ff, md_ff;
   side_a_type s5_ff;

   quad_type       numer_s6_ff, denom_s6_ff;
   logic [Q_W-1:0] mag_ff;
   side_a_type     s6_ff;

   quad_type   numer_ff, denom_ff;
   side_a_type s7_ff;

   quad_type   denom_in, denom_neg;
   side_a_type s7_in;

   // rebuild a full product from its four partial products
   function automatic logic signed [2*E_W-1:0] join_product(
         logic signed [2*H_W-1:0] hh, logic signed [H_W+L_W:0] hl,
         logic signed [H_W+L_W:0] lh, logic [2*L_W-1:0] ll);
      return $signed({hh, ll} + ((2*E_W)'(hl) << L_W) + ((2*E_W)'(lh) << L_W));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_LAT-2:0], in_valid};
      end
   end

   // differences
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         p1_s1_ff[k]  <= pa1[k];
         p3_s1_ff[k]  <= pb1[k];
         d13_ff[k]    <= D_W'(pa1[k]) - D_W'(pb1[k]);
         d43_s1_ff[k] <= D_W'(pb2[k]) - D_W'(pb1[k]);
         d21_s1_ff[k] <= D_W'(pa2[k]) - D_W'(pa1[k]);
      end
   end

   // a line is degenerate when every axis of its direction is tiny
   always_comb begin
      small43 = 1'b1;
      small21 = 1'b1;
      for (int k = 0; k < 3; k++) begin
         logic [D_W-1:0] m43, m21;
         m43 = d43_s1_ff[k][D_W-1] ? D_W'(-d43_s1_ff[k]) : D_W'(d43_s1_ff[k]);
         m21 = d21_s1_ff[k][D_W-1] ? D_W'(-d21_s1_ff[k]) : D_W'(d21_s1_ff[k]);
         if (m43 >= D_W'(leps)) small43 = 1'b0;
         if (m21 >= D_W'(leps)) small21 = 1'b0;
      end
   end

   // per-axis products
   always_ff @(posedge clock) begin
      deg_s2_ff <= small43 || small21;
      for (int k = 0; k < 3; k++) begin
         p1_s2_ff[k]  <= p1_s1_ff[k];
         p3_s2_ff[k]  <= p3_s1_ff[k];
         d43_s2_ff[k] <= d43_s1_ff[k];
         d21_s2_ff[k] <= d21_s1_ff[k];
         pr1343_ff[k] <= d13_ff[k] * d43_s1_ff[k];
         pr4321_ff[k] <= d43_s1_ff[k] * d21_s1_ff[k];
         pr1321_ff[k] <= d13_ff[k] * d21_s1_ff[k];
         pr4343_ff[k] <= d43_s1_ff[k] * d43_s1_ff[k];
         pr2121_ff[k] <= d21_s1_ff[k] * d21_s1_ff[k];
      end
   end

   // dot products
   always_ff @(posedge clock) begin
      s3_ff.bad   <= deg_s2_ff;
      s3_ff.e1343 <= E_W'(pr1343_ff[0]) + E_W'(pr1343_ff[1]) + E_W'(pr1343_ff[2]);
      s3_ff.e4321 <= E_W'(pr4321_ff[0]) + E_W'(pr4321_ff[1]) + E_W'(pr4321_ff[2]);
      s3_ff.e4343 <= E_W'(pr4343_ff[0]) + E_W'(pr4343_ff[1]) + E_W'(pr4343_ff[2]);
      e1321_ff    <= E_W'(pr1321_ff[0]) + E_W'(pr1321_ff[1]) + E_W'(pr1321_ff[2]);
      e2121_ff    <= E_W'(pr2121_ff[0]) + E_W'(pr2121_ff[1]) + E_W'(pr2121_ff[2]);
      s3_ff.p1    <= p1_s2_ff;
      s3_ff.p3    <= p3_s2_ff;
      s3_ff.d21   <= d21_s2_ff;
      s3_ff.d43   <= d43_s2_ff;
   end

   // cross products of the dots, as half-width partial products
   always_comb begin
      mul_x = '{e2121_ff, s3_ff.e4321, s3_ff.e1343, e1321_ff};
      mul_y = '{s3_ff.e4343, s3_ff.e4321, s3_ff.e4321, s3_ff.e4343};
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pp_hh_ff[k] <= $signed(mul_x[k][E_W-1:L_W]) * $signed(mul_y[k][E_W-1:L_W]);
         pp_hl_ff[k] <= $signed(mul_x[k][E_W-1:L_W]) * $signed({1'b0, mul_y[k][L_W-1:0]});
         pp_lh_ff[k] <= $signed({1'b0, mul_x[k][L_W-1:0]}) * $signed(mul_y[k][E_W-1:L_W]);
         pp_ll_ff[k] <= mul_x[k][L_W-1:0] * mul_y[k][L_W-1:0];
      end
      s4_ff <= s3_ff;
   end

   always_ff @(posedge clock) begin
      ma_ff <= join_product(pp_hh_ff[0], pp_hl_ff[0], pp_lh_ff[0], pp_ll_ff[0]);
      mb_ff <= join_product(pp_hh_ff[1], pp_hl_ff[1], pp_lh_ff[1], pp_ll_ff[1]);
      mc_ff <= join_product(pp_hh_ff[2], pp_hl_ff[2], pp_lh_ff[2], pp_ll_ff[2]);
      md_ff <= join_product(pp_hh_ff[3], pp_hl_ff[3], pp_lh_ff[3], pp_ll_ff[3]);
      s5_ff <= s4_ff;
   end

   // determinant, numerator and determinant magnitude
   always_comb begin
      denom_in  = Q_W'(ma_ff) - Q_W'(mb_ff);
      denom_neg = Q_W'(mb_ff) - Q_W'(ma_ff);
   end

   always_ff @(posedge clock) begin
      denom_s6_ff <= denom_in;
      numer_s6_ff <= Q_W'(mc_ff) - Q_W'(md_ff);
      mag_ff      <= denom_in[Q_W-1] ? denom_neg : denom_in;
      s6_ff       <= s5_ff;
   end

   // parallel test
   always_comb begin
      s7_in     = s6_ff;
      s7_in.bad = s6_ff.bad || (mag_ff == '0) || (mag_ff < Q_W'(deps));
   end

   always_ff @(posedge clock) begin
      denom_ff <= denom_s6_ff;
      numer_ff <= numer_s6_ff;
      s7_ff    <= s7_in;
   end

   assign out_valid = vld_ff[FRONT_LAT-1];
   assign numer     = numer_ff;
   assign denom     = denom_ff;
   assign side      = s7_ff;

endmodule
`default_nettype wire

@@ design/line_line_closest_points.sv @@
// Closest points between two 3D lines, Q16.16, fully pipelined.
// Path from start to rsp_valid: front pipeline, divider, t multiply-add, divider, near points.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Synchronous active-high reset clears valid bits and sets both thresholds to 1.
`default_nettype none
module line_line_closest_points import llcp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  coord_type             req_a_first_x,
   input  coord_type             req_a_first_y,
   input  coord_type             req_a_first_z,
   input  coord_type             req_a_second_x,
   input  coord_type             req_a_second_y,
   input  coord_type             req_a_second_z,
   input  coord_type             req_b_first_x,
   input  coord_type             req_b_first_y,
   input  coord_type             req_b_first_z,
   input  coord_type             req_b_second_x,
   input  coord_type             req_b_second_y,
   input  coord_type             req_b_second_z,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output coord_type             rsp_near_a_x,
   output coord_type             rsp_near_a_y,
   output coord_type             rsp_near_a_z,
   output coord_type             rsp_near_b_x,
   output coord_type             rsp_near_b_y,
   output coord_type             rsp_near_b_z,
   output coord_type             rsp_param_a,
   output coord_type             rsp_param_b,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // truncate toward zero on the fraction, add the base point, clamp
   function automatic coord_type near_point(nprod_type prod, coord_type base);
      nprod_type                         biased;
      logic signed [NP_W-FRAC_BITS:0]    sum;
      logic [NP_W-FRAC_BITS-COORD_WIDTH+1:0] upper;
      biased = prod + (prod[NP_W-1] ? FRAC_MASK : nprod_type'(0));
      sum    = (NP_W-FRAC_BITS+1)'($signed(biased[NP_W-1:FRAC_BITS]))
             + (NP_W-FRAC_BITS+1)'(base);
      upper  = sum[NP_W-FRAC_BITS:COORD_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         return coord_type'(sum[COORD_WIDTH-1:0]);
      end
      return sum[NP_W-FRAC_BITS] ? COORD_MIN : COORD_MAX;
   endfunction

   //---------------------------------------------------------------------
   // Configuration registers; pready is tied high so a write lands on
   // the access cycle.
   //---------------------------------------------------------------------
   logic [LEPS_W-1:0] leps_ff;
   logic [DEPS_W-1:0] deps_ff;
   logic [0:0]        csr_idx;
   logic              csr_write;

   assign csr_idx   = paddr[2:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         leps_ff <= LEPS_RESET;
         deps_ff <= DEPS_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_LEPS: begin
               leps_ff <= pwdata[LEPS_W-1:0];
            end
            REG_DEPS: begin
               deps_ff <= pwdata[DEPS_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LEPS: begin
            prdata = CSR_DATA_W'(leps_ff);
         end
         REG_DEPS: begin
            prdata = CSR_DATA_W'(deps_ff);
         end
      endcase
   end

   //---------------------------------------------------------------------
   // Front end: the pipeline never stalls, so every start is taken.
   //---------------------------------------------------------------------
   coord_type  pa1 [3], pa2 [3], pb1 [3], pb2 [3];
   logic       fr_valid;
   quad_type   fr_numer, fr_denom;
   side_a_type fr_side;

   assign busy = 1'b0;
   assign pa1  = '{req_a_first_x, req_a_first_y, req_a_first_z};
   assign pa2  = '{req_a_second_x, req_a_second_y, req_a_second_z};
   assign pb1  = '{req_b_first_x, req_b_first_y, req_b_first_z};
   assign pb2  = '{req_b_second_x, req_b_second_y, req_b_second_z};

   llcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .pa1       (pa1),
      .pa2       (pa2),
      .pb1       (pb1),
      .pb2       (pb2),
      .leps      (leps_ff),
      .deps      (deps_ff),
      .out_valid (fr_valid),
      .numer     (fr_numer),
      .denom     (fr_denom),
      .side      (fr_side)
   );

   //---------------------------------------------------------------------
   // mua = numer * 2^F / denom; side data shifts alongside the divider.
   //---------------------------------------------------------------------
   logic       mua_valid;
   coord_type  mua;
   side_a_type sa_ff [DIV_LAT];

   llcp_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .num       (N_W'(fr_numer) <<< FRAC_BITS),
      .den       (fr_denom),
      .out_valid (mua_valid),
      .quot      (mua)
   );

   always_ff @(posedge clock) begin
      sa_ff[0] <= fr_side;
      for (int i = 1; i < DIV_LAT; i++) begin
         sa_ff[i] <= sa_ff[i-1];
      end
   end

   //---------------------------------------------------------------------
   // t = e1343 * 2^F + e4321 * mua: multiply by halves, then add.
   //---------------------------------------------------------------------
   logic                      m1_valid_ff, m2_valid_ff;
   logic signed [H_W+COORD_WIDTH-1:0] m1_ph_ff;
   logic signed [L_W+COORD_WIDTH:0]   m1_pl_ff;
   logic signed [E_W+FRAC_BITS-1:0] m1_shift_ff;
   dot_type                   m1_e4343_ff, m2_e4343_ff;
   side_b_type                m1_side_ff, m2_side_ff;
   logic signed [T_W-1:0]     m2_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= mua_valid;
         m2_valid_ff <= m1_valid_ff;
      end
      m1_ph_ff         <= $signed(sa_ff[DIV_LAT-1].e4321[E_W-1:L_W]) * mua;
      m1_pl_ff         <= $signed({1'b0, sa_ff[DIV_LAT-1].e4321[L_W-1:0]}) * mua;
      m1_shift_ff      <= (E_W+FRAC_BITS)'(sa_ff[DIV_LAT-1].e1343) <<< FRAC_BITS;
      m1_e4343_ff      <= sa_ff[DIV_LAT-1].e4343;
      m1_side_ff.bad   <= sa_ff[DIV_LAT-1].bad;
      m1_side_ff.mua   <= mua;
      m1_side_ff.p1    <= sa_ff[DIV_LAT-1].p1;
      m1_side_ff.p3    <= sa_ff[DIV_LAT-1].p3;
      m1_side_ff.d21   <= sa_ff[DIV_LAT-1].d21;
      m1_side_ff.d43   <= sa_ff[DIV_LAT-1].d43;

      m2_t_ff          <= (T_W'(m1_ph_ff) <<< L_W) + T_W'(m1_pl_ff) + T_W'(m1_shift_ff);
      m2_e4343_ff      <= m1_e4343_ff;
      m2_side_ff       <= m1_side_ff;
   end

   //---------------------------------------------------------------------
   // mub = t / e4343
   //---------------------------------------------------------------------
   logic       mub_valid;
   coord_type  mub;
   side_b_type sb_ff [DIV_LAT];

   llcp_div u_div_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_valid_ff),
      .num       (N_W'(m2_t_ff)),
      .den       (Q_W'(m2_e4343_ff)),
      .out_valid (mub_valid),
      .quot      (mub)
   );

   always_ff @(posedge clock) begin
      sb_ff[0] <= m2_side_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         sb_ff[i] <= sb_ff[i-1];
      end
   end

   //---------------------------------------------------------------------
   // Near points: scale the directions, then truncate, offset and clamp.
   // Drop everything to zero when a line is degenerate or they are parallel.
   //---------------------------------------------------------------------
   logic      n_valid_ff, n_bad_ff;
   nprod_type na_prod_ff [3], nb_prod_ff [3];
   coord_type n_p1_ff [3], n_p3_ff [3];
   coord_type n_mua_ff, n_mub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else begin
         n_valid_ff <= mub_valid;
      end
      n_bad_ff <= sb_ff[DIV_LAT-1].bad;
      n_mua_ff <= sb_ff[DIV_LAT-1].mua;
      n_mub_ff <= mub;
      for (int k = 0; k < 3; k++) begin
         na_prod_ff[k] <= sb_ff[DIV_LAT-1].mua * sb_ff[DIV_LAT-1].d21[k];
         nb_prod_ff[k] <= mub * sb_ff[DIV_LAT-1].d43[k];
         n_p1_ff[k]    <= sb_ff[DIV_LAT-1].p1[k];
         n_p3_ff[k]    <= sb_ff[DIV_LAT-1].p3[k];
      end
   end

   logic      valid_ff, found_ff;
   coord_type near_a_ff [3], near_b_ff [3];
   coord_type param_a_ff, param_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= n_valid_ff;
      end
      found_ff   <= !n_bad_ff;
      param_a_ff <= n_bad_ff ? coord_type'(0) : n_mua_ff;
      param_b_ff <= n_bad_ff ? coord_type'(0) : n_mub_ff;
      for (int k = 0; k < 3; k++) begin
         near_a_ff[k] <= n_bad_ff ? coord_type'(0) : near_point(na_prod_ff[k], n_p1_ff[k]);
         near_b_ff[k] <= n_bad_ff ? coord_type'(0) : near_point(nb_prod_ff[k], n_p3_ff[k]);
      end
   end

   // each response shows for exactly one cycle
   assign rsp_valid    = valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_near_a_x = near_a_ff[0];
   assign rsp_near_a_y = near_a_ff[1];
   assign rsp_near_a_z = near_a_ff[2];
   assign rsp_near_b_x = near_b_ff[0];
   assign rsp_near_b_y = near_b_ff[1];
   assign rsp_near_b_z = near_b_ff[2];
   assign rsp_param_a  = param_a_ff;
   assign rsp_param_b  = param_b_ff;

endmodule
`default_nettype wire
